/* rtl/core/spwm_pkg.sv */
// ----------------------------------------------------------------------------
// spwm_pkg: shared types and constants for the relay pwm driver
// Level and duty widths, period constants and mode codes.
// ----------------------------------------------------------------------------
package spwm_pkg;

  // payload types
  typedef logic signed [15:0] level_t;
  typedef logic [6:0]         ticks_t;
  typedef logic [1:0]         mode_t;

  // period and clamp constants
  localparam int unsigned LevelLimit  = 1000;
  localparam int unsigned DutyShift   = 3;
  localparam ticks_t      PERIOD_TICKS = 7'd125;

  // mode codes
  localparam mode_t MODE_OFF      = 2'd0;
  localparam mode_t MODE_ON       = 2'd1;
  localparam mode_t MODE_DISABLED = 2'd2;

  // duty on-ticks from the controller level: |level| clamped, then shifted
  function automatic ticks_t duty_from_level(level_t level);
    logic [16:0] mag;
    logic [16:0] lim;
    mag = level[15] ? (17'h10000 - {1'b0, level}) : {1'b0, level};
    lim = (mag > 17'(LevelLimit)) ? 17'(LevelLimit) : mag;
    return ticks_t'(lim >> DutyShift);
  endfunction

endpackage

/* rtl/core/spwm_in_if.sv */
// ----------------------------------------------------------------------------
// spwm_in_if: tick channel into the relay pwm driver
// Valid/ready channel carrying the controller level and the power flag.
// ----------------------------------------------------------------------------
interface spwm_in_if import spwm_pkg::*; ();
  logic   valid;
  logic   ready;
  level_t drive_level;
  logic   power_on;

  modport source (output valid, output drive_level, output power_on, input ready);
  modport sink   (input valid, input drive_level, input power_on, output ready);
endinterface

/* rtl/core/spwm_out_if.sv */
// ----------------------------------------------------------------------------
// spwm_out_if: result channel out of the relay pwm driver
// Valid/ready channel carrying the relay drive and the current mode.
// ----------------------------------------------------------------------------
interface spwm_out_if import spwm_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  relay_on;
  mode_t mode_now;

  modport source (output valid, output relay_on, output mode_now, input ready);
  modport sink   (input valid, input relay_on, input mode_now, output ready);
endinterface

/* rtl/core/slow_pwm_relay_driver_core.sv */
// Path: a tick transfer loads the input register; the result register is loaded from it when
// the result side can take it, and the result transfer leaves from the result register.
// Throughput: one tick per cycle while the result side keeps taking transfers.
// The mode/timer update sits between the input register and the result register.
// Reset: mode is on, both timers are zero, both pipeline stages are empty.
// ----------------------------------------------------------------------------
// slow_pwm_relay_driver_core: time-proportioning relay drive
// Each tick turns the controller level into 0..125 on-ticks of a 125-tick
// period and steps an off/on/disabled mode machine with two down timers.
// ----------------------------------------------------------------------------
module slow_pwm_relay_driver_core import spwm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  spwm_in_if.sink          in_i,
  spwm_out_if.source       out_o
);

  // input stage
  logic   s1_vld_q;
  ticks_t s1_duty_q;
  logic   s1_pwr_q;

  // mode machine state
  mode_t  mode_q, mode_d;
  ticks_t low_q, low_d;
  ticks_t high_q, high_d;

  // result stage
  logic   out_vld_q;
  logic   relay_q, relay_d;
  mode_t  mode_out_q;

  logic   in_fire;
  logic   s2_rdy;
  logic   s2_fire;
  ticks_t low_time;

  // handshake flow
  assign s2_rdy     = !out_vld_q || out_o.ready;
  assign s2_fire    = s1_vld_q && s2_rdy;
  assign in_i.ready = !s1_vld_q || s2_rdy;
  assign in_fire    = in_i.valid && in_i.ready;

  // input register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_fire) begin
      s1_vld_q <= 1'b1;
    end else if (s2_fire) begin
      s1_vld_q <= 1'b0;
    end
  end

  // input register: payload, duty worked out on the way in
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_duty_q <= duty_from_level(in_i.drive_level);
      s1_pwr_q  <= in_i.power_on;
    end
  end

  assign low_time = PERIOD_TICKS - s1_duty_q;

  // mode machine next state
  always_comb begin
    mode_d  = mode_q;
    low_d   = low_q;
    high_d  = high_q;
    relay_d = 1'b0;
    case (mode_q)
      MODE_OFF: begin
        if (!s1_pwr_q) begin
          mode_d = MODE_DISABLED;
        end else if (low_q == '0) begin
          high_d = s1_duty_q;
          if (s1_duty_q != '0) mode_d = MODE_ON;
        end else begin
          low_d = low_q - 7'd1;
        end
      end
      MODE_ON: begin
        relay_d = 1'b1;
        if (!s1_pwr_q) begin
          mode_d = MODE_DISABLED;
        end else if (high_q == '0) begin
          low_d = low_time;
          if (low_time != '0) mode_d = MODE_OFF;
        end else begin
          high_d = high_q - 7'd1;
        end
      end
      default: begin
        if (s1_pwr_q) mode_d = MODE_ON;
      end
    endcase
  end

  // mode machine state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ON;
      low_q  <= '0;
      high_q <= '0;
    end else if (s2_fire) begin
      mode_q <= mode_d;
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

  // result register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s2_rdy) begin
      out_vld_q <= s1_vld_q;
    end
  end

  // result register: payload
  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      relay_q    <= relay_d;
      mode_out_q <= mode_d;
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.relay_on = relay_q;
  assign out_o.mode_now = mode_out_q;

`ifndef ASSERT_OFF
  // relay reflects the mode held when the tick was processed
  a_relay_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_fire |=> (relay_q == ($past(mode_q) == MODE_ON)))
    else $error("relay output does not match entry mode");

  // loss of power always lands in disabled
  a_power_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_fire && !s1_pwr_q) |=> (mode_q == MODE_DISABLED && mode_out_q == MODE_DISABLED))
    else $error("power loss did not disable the relay");

  // full duty with power keeps the relay on
  a_full_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_fire && s1_pwr_q && mode_q == MODE_ON && s1_duty_q == PERIOD_TICKS)
      |=> (mode_q == MODE_ON))
    else $error("full duty left on mode");

  // timers stay within one period
  a_timer_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (low_q <= PERIOD_TICKS) && (high_q <= PERIOD_TICKS))
    else $error("timer beyond period");
`endif

endmodule
